[sv/polyline_line_crossing_finder_macros.svh]
// Assertion macros used by the crossing finder top level.
`ifndef POLYLINE_LINE_CROSSING_FINDER_MACROS_SVH
`define POLYLINE_LINE_CROSSING_FINDER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst is high.
`define PCF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcf assertion failed");

// Next-cycle implication, clocked on clk, off while rst is high.
`define PCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcf assertion failed");

`endif

[sv/pcf_pkg.sv]
// Package: field widths, command codes and multiply-divide unit types.
package pcf_pkg;

  localparam int COORD_W = 24;
  localparam int IDX_W   = 10;
  localparam int SEG_W   = 11;
  localparam int NUM_W   = 11;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int MD_A_W = 25;
  localparam int MD_B_W = 52;
  localparam int MD_Q_W = 42;
  localparam int MD_P_W = MD_A_W + MD_B_W;

  typedef struct packed {
    logic                     start;
    logic signed [MD_A_W-1:0] a;
    logic signed [MD_B_W-1:0] b;
    logic signed [MD_B_W-1:0] d;
  } md_req_t;

  typedef struct packed {
    logic                     done;
    logic                     busy;
    logic signed [MD_Q_W-1:0] q;
  } md_rsp_t;

endpackage

[sv/pcf_if.sv]
// Request and response channel interfaces of the crossing finder.
interface pcf_req_if import pcf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [IDX_W-1:0]          vertex_index;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic signed [COORD_W-1:0] line_start_x;
  logic signed [COORD_W-1:0] line_start_y;
  logic signed [COORD_W-1:0] line_end_x;
  logic signed [COORD_W-1:0] line_end_y;

  modport source (output valid, cmd, vertex_index, vertex_x, vertex_y,
                  line_start_x, line_start_y, line_end_x, line_end_y,
                  input ready);
  modport sink (input valid, cmd, vertex_index, vertex_x, vertex_y,
                line_start_x, line_start_y, line_end_x, line_end_y,
                output ready);
endinterface

interface pcf_rsp_if import pcf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [SEG_W-1:0]   chosen_segment;
  logic                      used_midpoint;

  modport source (output valid, point_x, point_y, chosen_segment, used_midpoint,
                  input ready);
  modport sink (input valid, point_x, point_y, chosen_segment, used_midpoint,
                output ready);
endinterface

[sv/pcf_muldiv.sv]
// Sequential round(a*b/d) unit: shift-add multiply, restoring divide, round.
module pcf_muldiv import pcf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_DIV, M_RND} mstate_t;

  localparam logic [6:0] MUL_LAST = 7'(MD_A_W - 1);
  localparam logic [6:0] DIV_LAST = 7'(MD_P_W - 1);
  localparam logic [MD_P_W-1:0] Q_CLAMP = MD_P_W'(1) << 40;

  mstate_t            mstate;
  logic [6:0]         cnt;
  logic [MD_A_W-1:0]  ma;
  logic [MD_P_W-1:0]  mb;
  logic [MD_P_W-1:0]  prod;
  logic [MD_B_W-1:0]  md;
  logic [MD_B_W-1:0]  r;
  logic [MD_P_W-1:0]  q;
  logic               neg;
  logic               done;
  logic signed [MD_Q_W-1:0] qout;

  logic [MD_B_W:0]    rs;
  logic               ge;
  logic [MD_P_W-1:0]  qr;
  logic [MD_P_W-1:0]  cq;
  logic signed [MD_Q_W-1:0] qsig;

  assign rs   = {r, prod[MD_P_W-1]};
  assign ge   = rs >= {1'b0, md};
  assign qr   = q + MD_P_W'(r >= (md - r));
  assign cq   = (qr > Q_CLAMP) ? Q_CLAMP : qr;
  assign qsig = signed'(MD_Q_W'(cq));

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      mstate <= M_IDLE;
      cnt    <= '0;
    end else begin
      unique case (mstate)
        M_IDLE: begin
          if (req.start) begin
            ma     <= req.a[MD_A_W-1] ? MD_A_W'(-req.a) : MD_A_W'(req.a);
            mb     <= MD_P_W'(req.b[MD_B_W-1] ? MD_B_W'(-req.b) : MD_B_W'(req.b));
            md     <= req.d[MD_B_W-1] ? MD_B_W'(-req.d) : MD_B_W'(req.d);
            neg    <= (req.a[MD_A_W-1] ^ req.b[MD_B_W-1]) ^ req.d[MD_B_W-1];
            prod   <= '0;
            cnt    <= '0;
            mstate <= M_MUL;
          end
        end
        M_MUL: begin
          if (ma[0]) prod <= prod + mb;
          ma  <= ma >> 1;
          mb  <= mb << 1;
          cnt <= cnt + 7'd1;
          if (cnt == MUL_LAST) begin
            cnt    <= '0;
            r      <= '0;
            q      <= '0;
            mstate <= M_DIV;
          end
        end
        M_DIV: begin
          r    <= ge ? MD_B_W'(rs - {1'b0, md}) : MD_B_W'(rs);
          q    <= {q[MD_P_W-2:0], ge};
          prod <= prod << 1;
          cnt  <= cnt + 7'd1;
          if (cnt == DIV_LAST) mstate <= M_RND;
        end
        M_RND: begin
          qout   <= neg ? -qsig : qsig;
          done   <= 1'b1;
          mstate <= M_IDLE;
        end
        default: mstate <= M_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.busy = mstate != M_IDLE;
  assign rsp.q    = qout;

endmodule

[sv/polyline_line_crossing_finder.sv]
// Top level: polyline vertex memory, crossing search sequencer and output register.
//
// Usage: items arrive on req (valid/ready). cmd = load writes one vertex into the
// vertex memory in the cycle it is accepted, if vertex_index is below MAX_POINTS,
// and gives no result. cmd = query gives exactly one result on rsp (valid/ready).
// The user writes num_points through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. A query fetches vertices one at
// a time through the single read port of the vertex memory; each fetch goes
// through a memory read, the side products and a subtract. The hint checks take
// up to 6 fetches, the end test 2, the binary search about log2(num_points) and
// the final segment 2 more. A crossing or projection then runs the shared
// multiply-divide unit twice, each run being 25 multiply steps, 77 divide steps
// and rounding; a midpoint result skips the division. Loads are accepted back
// to back while the block is idle, each being written as it is accepted.
// Reset clears the hint (segment 0, forward), sets num_points to 2 and drops
// any pending result; the vertex memory is not cleared. A stalled receiver
// holds the result in the output register; loads are still taken meanwhile,
// and a finished query waits in its last step until the register is free.
`include "polyline_line_crossing_finder_macros.svh"

module polyline_line_crossing_finder import pcf_pkg::*; #(
  parameter int MAX_POINTS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  pcf_req_if.sink          req,
  pcf_rsp_if.source        rsp,
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata
);

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW   = AW + 1;
  localparam int SW   = AW + 1;
  localparam int CW   = AW + 2;
  localparam int CMPW = (NW > NUM_W) ? NW : NUM_W;
  localparam int IW   = (NW > IDX_W) ? NW : IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CAND, S_RD, S_MUL, S_SUB, S_BS, S_CALC,
    S_PROJ1, S_PROJ2, S_PROJ3, S_DIV, S_WAIT, S_FIN
  } state_t;

  typedef enum logic [2:0] {PH_PAIR, PH_FIN, PH_END0, PH_END1, PH_MID} phase_t;

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [42:0] v);
    if (v > 43'sd8388607) return 24'sd8388607;
    if (v < -43'sd8388608) return -24'sd8388608;
    return COORD_W'(v);
  endfunction

  function automatic logic opposite(input logic signed [50:0] a,
                                    input logic signed [50:0] b);
    return (a == '0) || (b == '0) || (a[50] != b[50]);
  endfunction

  function automatic logic [50:0] abs51(input logic signed [50:0] a);
    return a[50] ? 51'(-a) : 51'(a);
  endfunction

  state_t state;
  phase_t phase;

  logic [NUM_W-1:0]          num_q;
  logic signed [COORD_W-1:0] lx1, ly1;
  logic signed [24:0]        ldx, ldy;
  logic signed [SW-1:0]      last_seg;
  logic                      search_bwd;
  logic [1:0]                k;
  logic                      half;
  logic signed [CW-1:0]      c_reg;
  logic [AW-1:0]             rd_addr;
  logic [47:0]               rdata;
  logic signed [49:0]        p1, p2;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [50:0]        s1, s2;
  logic signed [COORD_W-1:0] x1, y1, x2, y2;
  logic [AW-1:0]             left, right, mid;
  logic signed [50:0]        ld;
  logic signed [SW-1:0]      seg_q;
  logic                      used_mid;
  logic signed [24:0]        op_ax, op_ay;
  logic signed [51:0]        op_b, op_d;
  logic signed [COORD_W-1:0] base_x, base_y;
  logic                      dsel;
  logic signed [COORD_W-1:0] resx, resy;

  logic                      out_v;
  logic signed [COORD_W-1:0] out_x, out_y;
  logic signed [SEG_W-1:0]   out_seg;
  logic                      out_mid;

  logic [47:0] mem [MAX_POINTS];

  // Vertex count in use, clamped to the supported range.
  logic [CMPW-1:0] np_ext;
  logic [NW-1:0]   n_used, nseg;
  always_comb begin
    np_ext = CMPW'(num_q);
    if (np_ext < CMPW'(2)) n_used = NW'(2);
    else if (np_ext > CMPW'(MAX_POINTS)) n_used = NW'(MAX_POINTS);
    else n_used = NW'(np_ext);
  end
  assign nseg = n_used - NW'(1);

  logic                   acc, load_ok, mem_we;
  logic signed [CW-1:0]   stepx, lastx, cand, nseg_s;
  logic                   cand_ok;
  logic signed [COORD_W-1:0] rx, ry;
  logic signed [24:0]     dxv, dyv;
  logic signed [50:0]     side;
  logic [AW:0]            lsum;
  logic signed [42:0]     div_sum;
  logic signed [SW-1:0]   left_s, nseg_seg;
  logic signed [COORD_W:0] midx, midy;
  md_req_t md_req;
  md_rsp_t md_rsp;

  assign acc     = req.valid && req.ready;
  assign load_ok = IW'(req.vertex_index) < IW'(MAX_POINTS);
  assign mem_we  = acc && (req.cmd == CMD_LOAD) && load_ok;

  assign stepx   = search_bwd ? '1 : CW'(1);
  assign lastx   = CW'(last_seg);
  assign nseg_s  = signed'({1'b0, nseg});
  always_comb begin
    case (k)
      2'd0:    cand = lastx;
      2'd1:    cand = lastx + stepx;
      default: cand = lastx - stepx;
    endcase
  end
  assign cand_ok = (cand >= 0) && (cand < nseg_s);

  assign rx   = rdata[47:24];
  assign ry   = rdata[23:0];
  assign dxv  = 25'(rx) - 25'(lx1);
  assign dyv  = 25'(ry) - 25'(ly1);
  assign side = 51'(p1) - 51'(p2);
  assign lsum = {1'b0, left} + {1'b0, right};
  assign div_sum  = 43'(dsel ? base_y : base_x) + 43'(md_rsp.q);
  assign left_s   = signed'({1'b0, left});
  assign nseg_seg = signed'(nseg);
  assign midx = 25'(x1) + 25'(x2);
  assign midy = 25'(y1) + 25'(y2);

  assign md_req.start = state == S_DIV;
  assign md_req.a     = dsel ? op_ay : op_ax;
  assign md_req.b     = op_b;
  assign md_req.d     = op_d;

  pcf_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  always_ff @(posedge clk) begin
    if (mem_we) mem[AW'(req.vertex_index)] <= {req.vertex_x, req.vertex_y};
    if (state == S_RD) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_PAIR;
      num_q      <= NUM_W'(2);
      last_seg   <= '0;
      search_bwd <= 1'b0;
      out_v      <= 1'b0;
      k          <= '0;
      half       <= 1'b0;
      dsel       <= 1'b0;
    end else begin
      if (cfg_we) num_q <= cfg_wdata;
      if (out_v && rsp.ready) out_v <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (acc && req.cmd == CMD_QUERY) begin
            lx1   <= req.line_start_x;
            ly1   <= req.line_start_y;
            ldx   <= 25'(req.line_end_x) - 25'(req.line_start_x);
            ldy   <= 25'(req.line_end_y) - 25'(req.line_start_y);
            k     <= '0;
            state <= S_CAND;
          end
        end
        S_CAND: begin
          if (cand_ok) begin
            c_reg   <= cand;
            rd_addr <= AW'(cand);
            phase   <= PH_PAIR;
            half    <= 1'b0;
            state   <= S_RD;
          end else if (k == 2'd2) begin
            phase   <= PH_END0;
            rd_addr <= '0;
            state   <= S_RD;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_RD: state <= S_MUL;
        S_MUL: begin
          p1    <= ldy * dxv;
          p2    <= ldx * dyv;
          cur_x <= rx;
          cur_y <= ry;
          state <= S_SUB;
        end
        S_SUB: begin
          unique case (phase)
            PH_PAIR, PH_FIN: begin
              if (!half) begin
                s1      <= side;
                x1      <= cur_x;
                y1      <= cur_y;
                half    <= 1'b1;
                rd_addr <= AW'(c_reg) + AW'(1);
                state   <= S_RD;
              end else begin
                s2 <= side;
                x2 <= cur_x;
                y2 <= cur_y;
                if (phase == PH_FIN) begin
                  state <= S_CALC;
                end else if (opposite(s1, side)) begin
                  seg_q <= signed'(c_reg[SW-1:0]);
                  if (k != 2'd0) begin
                    search_bwd <= signed'(c_reg[SW-1:0]) < last_seg;
                    last_seg   <= signed'(c_reg[SW-1:0]);
                  end
                  state <= S_CALC;
                end else if (k == 2'd2) begin
                  phase   <= PH_END0;
                  rd_addr <= '0;
                  state   <= S_RD;
                end else begin
                  k     <= k + 2'd1;
                  state <= S_CAND;
                end
              end
            end
            PH_END0: begin
              s1      <= side;
              x1      <= cur_x;
              y1      <= cur_y;
              phase   <= PH_END1;
              rd_addr <= AW'(nseg);
              state   <= S_RD;
            end
            PH_END1: begin
              if (!opposite(s1, side)) begin
                // Line misses the polyline: project the nearer end vertex.
                if (abs51(s1) < abs51(side)) begin
                  seg_q      <= '1;
                  search_bwd <= signed'(SW'(-1)) < last_seg;
                  last_seg   <= '1;
                end else begin
                  seg_q      <= nseg_seg;
                  search_bwd <= nseg_seg < last_seg;
                  last_seg   <= nseg_seg;
                  x1         <= cur_x;
                  y1         <= cur_y;
                end
                state <= S_PROJ1;
              end else begin
                left  <= '0;
                right <= AW'(nseg);
                ld    <= s1;
                state <= S_BS;
              end
            end
            PH_MID: begin
              if (opposite(side, ld)) begin
                right <= mid;
              end else begin
                left <= mid;
                ld   <= side;
              end
              state <= S_BS;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_BS: begin
          if ({1'b0, left} + (AW+1)'(1) < {1'b0, right}) begin
            mid     <= AW'(lsum >> 1);
            rd_addr <= AW'(lsum >> 1);
            phase   <= PH_MID;
            state   <= S_RD;
          end else begin
            seg_q      <= left_s;
            search_bwd <= left_s < last_seg;
            last_seg   <= left_s;
            c_reg      <= CW'(left_s);
            rd_addr    <= left;
            phase      <= PH_FIN;
            half       <= 1'b0;
            state      <= S_RD;
          end
        end
        S_CALC: begin
          if (s1 == s2) begin
            resx     <= COORD_W'(midx >>> 1);
            resy     <= COORD_W'(midy >>> 1);
            used_mid <= 1'b1;
            state    <= S_FIN;
          end else begin
            used_mid <= 1'b0;
            op_ax    <= 25'(x2) - 25'(x1);
            op_ay    <= 25'(y2) - 25'(y1);
            op_b     <= 52'(s1);
            op_d     <= 52'(s1) - 52'(s2);
            base_x   <= x1;
            base_y   <= y1;
            dsel     <= 1'b0;
            state    <= S_DIV;
          end
        end
        S_PROJ1: begin
          used_mid <= 1'b0;
          p1       <= ldx * ldx;
          p2       <= ldy * ldy;
          state    <= S_PROJ2;
        end
        S_PROJ2: begin
          op_d  <= 52'(p1) + 52'(p2);
          p1    <= ldx * (25'(x1) - 25'(lx1));
          p2    <= ldy * (25'(y1) - 25'(ly1));
          state <= S_PROJ3;
        end
        S_PROJ3: begin
          op_b   <= 52'(p1) + 52'(p2);
          op_ax  <= ldx;
          op_ay  <= ldy;
          base_x <= lx1;
          base_y <= ly1;
          dsel   <= 1'b0;
          if (op_d == '0) begin
            resx  <= lx1;
            resy  <= ly1;
            state <= S_FIN;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (md_rsp.done) begin
            if (!dsel) begin
              resx  <= sat24(div_sum);
              dsel  <= 1'b1;
              state <= S_DIV;
            end else begin
              resy  <= sat24(div_sum);
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          // Hold until the output register is free.
          if (!out_v || rsp.ready) begin
            out_v   <= 1'b1;
            out_x   <= resx;
            out_y   <= resy;
            out_seg <= SEG_W'(seg_q);
            out_mid <= used_mid;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready          = state == S_IDLE;
  assign rsp.valid          = out_v;
  assign rsp.point_x        = out_x;
  assign rsp.point_y        = out_y;
  assign rsp.chosen_segment = out_seg;
  assign rsp.used_midpoint  = out_mid;

  `PCF_ASSERT_IMPL(a_bs_order, state == S_BS, left < right)
  `PCF_ASSERT_NEXT(a_query_busy, acc && req.cmd == CMD_QUERY, state != S_IDLE)
  `PCF_ASSERT_IMPL(a_div_free, state == S_DIV, !md_rsp.busy)
  `PCF_ASSERT_NEXT(a_load_silent, acc && req.cmd == CMD_LOAD && !out_v, !out_v)

endmodule
